// ===== sv/shared_server_makespan_eval_top_defines.svh =====
// Assertion macros shared by the makespan evaluator RTL.
`ifndef SHARED_SERVER_MAKESPAN_EVAL_TOP_DEFINES_SVH
`define SHARED_SERVER_MAKESPAN_EVAL_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SSME_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SSME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSME_ASSERT_IMPL(lbl, ante, cons, msg)
`define SSME_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/ssme_pkg.sv =====
// Package: widths, defaults and ALU operation codes of the makespan evaluator.
`default_nettype none

package ssme_pkg;

  // Defaults of the top-level parameters
  localparam int unsigned MAX_MACHINES_DEF = 16;
  localparam int unsigned TIME_BITS_DEF    = 32;

  // Fixed field widths
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned MACH_W     = 4;
  localparam int unsigned OUT_TIME_W = 32;

  // Reset value of the machine count register
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd2;

  // Operations of the shared arithmetic unit
  typedef enum logic [1:0] {
    ALU_LT,
    ALU_MAX,
    ALU_SATADD
  } alu_op_e;

endpackage

`default_nettype wire

// ===== sv/ssme_ifs.sv =====
// Valid/ready channel interfaces for jobs in and results out.
`default_nettype none

interface ssme_job_if;
  logic                            valid;
  logic                            ready;
  logic [ssme_pkg::DUR_W-1:0]      setup_time;
  logic [ssme_pkg::DUR_W-1:0]      processing_time;
  logic                            last_job;

  modport source (output valid, output setup_time, output processing_time,
                  output last_job, input ready);
  modport sink   (input valid, input setup_time, input processing_time,
                  input last_job, output ready);
endinterface

interface ssme_res_if;
  logic                            valid;
  logic                            ready;
  logic [ssme_pkg::MACH_W-1:0]     assigned_machine;
  logic [ssme_pkg::OUT_TIME_W-1:0] setup_end;
  logic [ssme_pkg::OUT_TIME_W-1:0] completion;
  logic [ssme_pkg::OUT_TIME_W-1:0] makespan;
  logic                            final_res;

  modport source (output valid, output assigned_machine, output setup_end,
                  output completion, output makespan, output final_res,
                  input ready);
  modport sink   (input valid, input assigned_machine, input setup_end,
                  input completion, input makespan, input final_res,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/ssme_alu.sv =====
// Shared time unit: unsigned compare, maximum and saturating add.
`default_nettype none

module ssme_alu #(
  parameter int unsigned TIME_BITS = ssme_pkg::TIME_BITS_DEF
) (
  input  wire ssme_pkg::alu_op_e     op_i,
  input  wire logic [TIME_BITS-1:0]  a_i,
  input  wire logic [TIME_BITS-1:0]  b_i,
  output logic      [TIME_BITS-1:0]  res_o,
  output logic                       lt_o
);
  import ssme_pkg::*;

  logic [TIME_BITS:0] sum;

  // One wide add with carry out, one compare
  assign sum  = {1'b0, a_i} + {1'b0, b_i};
  assign lt_o = (a_i < b_i);

  // Select the result, clamp the sum at the top of the time range
  always_comb begin
    unique case (op_i)
      ALU_LT:     res_o = lt_o ? a_i : b_i;
      ALU_MAX:    res_o = lt_o ? b_i : a_i;
      ALU_SATADD: res_o = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
      default:    res_o = a_i;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/shared_server_makespan_eval_top.sv =====
// Top level: list-scheduling makespan evaluator with one shared setup server.
//
//  channel   dir  handshake            payload
//  job_i     in   valid/ready          setup_time, processing_time, last_job
//  res_o     out  valid/ready          assigned_machine, setup_end, completion,
//                                      makespan, final_res
//  cfg       in   cfg_we_i (no wait)   cfg_wdata_i = machines_in_use
//
// Between one acceptance and the next, each of the N machines in use, N being
// machines_in_use clamped to 1..MAX_MACHINES, has its free time read through the
// single read port of the free-time memory; then the scan drains, four passes go
// through the shared time unit (start, setup end, completion, makespan) and the
// sequencer returns to idle with ready high.
// Reset clears the free-time valid bits, server time and makespan at once;
// a closing job clears them the same way after its item is issued.
// A stalled result holds in the output register; the next job may be taken
// meanwhile and waits at its final step only while that register is full.
`default_nettype none

`include "shared_server_makespan_eval_top_defines.svh"

module shared_server_makespan_eval_top #(
  parameter int unsigned MAX_MACHINES = ssme_pkg::MAX_MACHINES_DEF,
  parameter int unsigned TIME_BITS    = ssme_pkg::TIME_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ssme_pkg::CFG_W-1:0]  cfg_wdata_i,
  ssme_job_if.sink                         job_i,
  ssme_res_if.source                       res_o
);
  import ssme_pkg::*;

  localparam int unsigned IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_MACHINES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_START,
    ST_SETUP,
    ST_PROC,
    ST_WRITE
  } state_e;

  // Control and job registers
  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       cfg_q, cfg_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       issue_q, issue_d;
  logic                   pend_q, pend_d;
  logic [IDX_W-1:0]       pend_idx_q, pend_idx_d;
  logic                   rd_live_q, rd_live_d;
  logic [DUR_W-1:0]       setup_q, setup_d;
  logic [DUR_W-1:0]       proc_q, proc_d;
  logic                   last_q, last_d;

  // Time state
  logic [MAX_MACHINES-1:0] vld_q, vld_d;
  logic [TIME_BITS-1:0]    server_q, server_d;
  logic [TIME_BITS-1:0]    ms_q, ms_d;
  logic [TIME_BITS-1:0]    best_q, best_d;
  logic [IDX_W-1:0]        best_idx_q, best_idx_d;
  logic [TIME_BITS-1:0]    send_q, send_d;
  logic [TIME_BITS-1:0]    done_q, done_d;

  // Result register
  logic                    res_vld_q, res_vld_d;
  logic [MACH_W-1:0]       res_mach_q, res_mach_d;
  logic [OUT_TIME_W-1:0]   res_send_q, res_send_d;
  logic [OUT_TIME_W-1:0]   res_done_q, res_done_d;
  logic [OUT_TIME_W-1:0]   res_ms_q, res_ms_d;
  logic                    res_fin_q, res_fin_d;

  // Free-time memory
  logic [TIME_BITS-1:0]    ftime_mem_q [MAX_MACHINES];
  logic [TIME_BITS-1:0]    rd_data_q;
  logic                    mem_re, mem_we;
  logic [IDX_W-1:0]        mem_raddr;

  // Shared unit
  alu_op_e                 alu_op;
  logic [TIME_BITS-1:0]    alu_a, alu_b, alu_res;
  logic                    alu_lt;

  logic [TIME_BITS-1:0]    cur_time;
  logic [CNT_W-1:0]        eff_cnt;
  logic                    out_free;

  ssme_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res),
    .lt_o  (alu_lt)
  );

  // Never-written machines read as free at time zero
  assign cur_time = rd_live_q ? rd_data_q : '0;
  assign out_free = !res_vld_q || res_o.ready;

  // Clamp the machine count to 1..MAX_MACHINES
  always_comb begin
    if (cfg_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (32'(cfg_q) > MAX_MACHINES) begin
      eff_cnt = CNT_W'(MAX_MACHINES);
    end else begin
      eff_cnt = CNT_W'(cfg_q);
    end
  end

  // Sequencer: scan, then four steps through the shared unit
  always_comb begin
    state_d    = state_q;
    cfg_d      = cfg_we_i ? cfg_wdata_i : cfg_q;
    count_d    = count_q;
    issue_d    = issue_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    setup_d    = setup_q;
    proc_d     = proc_q;
    last_d     = last_q;
    vld_d      = vld_q;
    server_d   = server_q;
    ms_d       = ms_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    send_d     = send_q;
    done_d     = done_q;
    res_vld_d  = res_o.ready ? 1'b0 : res_vld_q;
    res_mach_d = res_mach_q;
    res_send_d = res_send_q;
    res_done_d = res_done_q;
    res_ms_d   = res_ms_q;
    res_fin_d  = res_fin_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = issue_q[IDX_W-1:0];
    rd_live_d  = rd_live_q;
    alu_op     = ALU_LT;
    alu_a      = cur_time;
    alu_b      = best_q;

    unique case (state_q)
      ST_IDLE: begin
        if (job_i.valid) begin
          setup_d = job_i.setup_time;
          proc_d  = job_i.processing_time;
          last_d  = job_i.last_job;
          count_d = eff_cnt;
          issue_d = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue one read a cycle, compare the data of the previous read
        if (issue_q < count_q) begin
          mem_re     = 1'b1;
          rd_live_d  = vld_q[mem_raddr];
          issue_d    = issue_q + CNT_W'(1);
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IDX_W-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          // Strictly earlier wins, so ties keep the lower index
          if (pend_idx_q == '0 || alu_lt) begin
            best_d     = cur_time;
            best_idx_d = pend_idx_q;
          end
        end
        if (!pend_q && issue_q == count_q) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        alu_op  = ALU_MAX;
        alu_a   = best_q;
        alu_b   = server_q;
        send_d  = alu_res;
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        alu_op  = ALU_SATADD;
        alu_a   = send_q;
        alu_b   = TIME_BITS'(setup_q);
        send_d  = alu_res;
        state_d = ST_PROC;
      end
      ST_PROC: begin
        alu_op  = ALU_SATADD;
        alu_a   = send_q;
        alu_b   = TIME_BITS'(proc_q);
        done_d  = alu_res;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        alu_op = ALU_MAX;
        alu_a  = done_q;
        alu_b  = ms_q;
        // Hold until the result register can take the item
        if (out_free) begin
          mem_we             = 1'b1;
          vld_d[best_idx_q]  = 1'b1;
          server_d           = send_q;
          ms_d               = alu_res;
          res_vld_d          = 1'b1;
          res_mach_d         = MACH_W'(best_idx_q);
          res_send_d         = OUT_TIME_W'(send_q);
          res_done_d         = OUT_TIME_W'(done_q);
          res_ms_d           = OUT_TIME_W'(alu_res);
          res_fin_d          = last_q;
          // Closing job: drop all times of the schedule
          if (last_q) begin
            vld_d    = '0;
            server_d = '0;
            ms_d     = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_q      <= CFG_RESET;
      count_q    <= '0;
      issue_q    <= '0;
      pend_q     <= 1'b0;
      rd_live_q  <= 1'b0;
      vld_q      <= '0;
      server_q   <= '0;
      ms_q       <= '0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cfg_q      <= cfg_d;
      count_q    <= count_d;
      issue_q    <= issue_d;
      pend_q     <= pend_d;
      rd_live_q  <= rd_live_d;
      vld_q      <= vld_d;
      server_q   <= server_d;
      ms_q       <= ms_d;
      res_vld_q  <= res_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    setup_q    <= setup_d;
    proc_q     <= proc_d;
    last_q     <= last_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    send_q     <= send_d;
    done_q     <= done_d;
    res_mach_q <= res_mach_d;
    res_send_q <= res_send_d;
    res_done_q <= res_done_d;
    res_ms_q   <= res_ms_d;
    res_fin_q  <= res_fin_d;
  end

  // Free-time memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ftime_mem_q[best_idx_q] <= done_q;
    end
    if (mem_re) begin
      rd_data_q <= ftime_mem_q[mem_raddr];
    end
  end

  // Channel outputs
  assign job_i.ready            = (state_q == ST_IDLE);
  assign res_o.valid            = res_vld_q;
  assign res_o.assigned_machine = res_mach_q;
  assign res_o.setup_end        = res_send_q;
  assign res_o.completion       = res_done_q;
  assign res_o.makespan         = res_ms_q;
  assign res_o.final_res        = res_fin_q;

  // Checks
  `SSME_ASSERT_NEXT(a_accept_scan, job_i.valid && job_i.ready, state_q == ST_SCAN,
                    "accepted job did not start its scan")
  `SSME_ASSERT_IMPL(a_best_in_range, state_q == ST_START, 32'(best_idx_q) < 32'(count_q),
                    "chosen machine outside the machines in use")
  `SSME_ASSERT_NEXT(a_issue_result, state_q == ST_WRITE && out_free, res_vld_q,
                    "finished job issued no result")
  `SSME_ASSERT_NEXT(a_close_clears, state_q == ST_WRITE && out_free && last_q,
                    vld_q == '0 && server_q == '0 && ms_q == '0,
                    "closing job left schedule times behind")

endmodule

`default_nettype wire

// ===== sim/shared_server_makespan_eval_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the shared-server makespan evaluator: job driver, result checker, scoreboard.
module shared_server_makespan_eval_top_tb;
  import ssme_pkg::*;

  localparam int unsigned NMACH         = MAX_MACHINES_DEF;
  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned SEGMENT_JOBS  = 160;
  localparam int unsigned LONG_JOBS     = 24;
  localparam int unsigned REPORT_MAX    = 10;
  localparam logic [OUT_TIME_W-1:0] TIME_TOP = '1;
  localparam logic [DUR_W-1:0]      DUR_TOP  = '1;

  typedef struct packed {
    logic [DUR_W-1:0] setup_time;
    logic [DUR_W-1:0] processing_time;
    logic             last_job;
  } sched_job_t;

  typedef struct packed {
    logic [MACH_W-1:0]     assigned_machine;
    logic [OUT_TIME_W-1:0] setup_end;
    logic [OUT_TIME_W-1:0] completion;
    logic [OUT_TIME_W-1:0] makespan;
    logic                  final_res;
  } sched_res_t;

  // Schedule predictor and store of expected results
  class makespan_scoreboard;
    logic [OUT_TIME_W-1:0] free_at [NMACH];
    logic [OUT_TIME_W-1:0] server_free;
    logic [OUT_TIME_W-1:0] span;
    logic [CFG_W-1:0]      machines;
    sched_res_t            expected_q [$];
    int unsigned           errors;

    function new();
      machines = CFG_RESET;
      errors   = 0;
      clear_times();
    endfunction

    function void clear_times();
      foreach (free_at[i]) free_at[i] = '0;
      server_free = '0;
      span        = '0;
    endfunction

    function logic [OUT_TIME_W-1:0] sat_sum(logic [OUT_TIME_W-1:0] a, logic [DUR_W-1:0] b);
      logic [OUT_TIME_W:0] s;
      s = {1'b0, a} + (OUT_TIME_W+1)'(b);
      return s[OUT_TIME_W] ? TIME_TOP : s[OUT_TIME_W-1:0];
    endfunction

    // Place the job on the earliest-free machine and queue its result
    function void note_job(sched_job_t j);
      int unsigned           cnt;
      int unsigned           best;
      logic [OUT_TIME_W-1:0] best_t;
      logic [OUT_TIME_W-1:0] start;
      sched_res_t            r;
      cnt = 32'(machines);
      if (cnt == 0) cnt = 1;
      if (cnt > NMACH) cnt = NMACH;
      best   = 0;
      best_t = free_at[0];
      for (int unsigned i = 1; i < cnt; i++) begin
        if (free_at[i] < best_t) begin
          best_t = free_at[i];
          best   = i;
        end
      end
      start              = (best_t > server_free) ? best_t : server_free;
      r.assigned_machine = best[MACH_W-1:0];
      r.setup_end        = sat_sum(start, j.setup_time);
      r.completion       = sat_sum(r.setup_end, j.processing_time);
      server_free        = r.setup_end;
      free_at[best]      = r.completion;
      if (r.completion > span) span = r.completion;
      r.makespan  = span;
      r.final_res = j.last_job;
      expected_q.push_back(r);
      if (j.last_job) clear_times();
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: result with none expected: mach %0d se %0d c %0d ms %0d f %0b",
                   $time, got.assigned_machine, got.setup_end, got.completion,
                   got.makespan, got.final_res);
        return;
      end
      want = expected_q.pop_front();
      if (got.assigned_machine !== want.assigned_machine || got.setup_end !== want.setup_end ||
          got.completion !== want.completion || got.makespan !== want.makespan ||
          got.final_res !== want.final_res) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("%0t: mismatch, expected mach %0d se %0d c %0d ms %0d f %0b", $time,
                   want.assigned_machine, want.setup_end, want.completion, want.makespan,
                   want.final_res);
          $display("%0t:           actual   mach %0d se %0d c %0d ms %0d f %0b", $time,
                   got.assigned_machine, got.setup_end, got.completion, got.makespan,
                   got.final_res);
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      cycles;
  makespan_scoreboard sb;

  ssme_job_if job_if ();
  ssme_res_if res_if ();

  shared_server_makespan_eval_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_i       (job_if.sink),
    .res_o       (res_if.source)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Stop a hung run
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("shared_server_makespan_eval_top_tb: errors");
      $finish;
    end
  end

  // Result side: stall at random, check each accepted item
  initial begin
    sched_res_t got;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.assigned_machine = res_if.assigned_machine;
        got.setup_end        = res_if.setup_end;
        got.completion       = res_if.completion;
        got.makespan         = res_if.makespan;
        got.final_res        = res_if.final_res;
        sb.check_result(got);
      end
    end
  end

  // Offer one job, idling first at random; returns at a falling edge
  task automatic send_job(input sched_job_t j);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      job_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    job_if.valid           <= 1'b1;
    job_if.setup_time      <= j.setup_time;
    job_if.processing_time <= j.processing_time;
    job_if.last_job        <= j.last_job;
    do @(posedge clk_i); while (!job_if.ready);
    sb.note_job(j);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [DUR_W-1:0] s, input logic [DUR_W-1:0] p,
                             input bit l);
    sched_job_t j;
    j.setup_time      = s;
    j.processing_time = p;
    j.last_job        = l;
    send_job(j);
  endtask

  // Drop valid and wait until every expected item has come back
  task automatic drain();
    job_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_machines(input logic [CFG_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    sb.machines = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Durations biased towards ties, extremes and small values
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DUR_TOP;
      2, 3, 4: return DUR_W'($urandom_range(0, 15));
      5, 6:    return DUR_W'($urandom_range(0, 1000));
      default: return DUR_W'($urandom());
    endcase
  endfunction

  // Whole schedules of random length; the one cut by the item budget stays open
  task automatic run_segment(input logic [CFG_W-1:0] cfg_val);
    int unsigned sent;
    int unsigned len;
    sched_job_t  j;
    sent = 0;
    write_machines(cfg_val);
    while (sent < SEGMENT_JOBS) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      for (int unsigned k = 0; k < len && sent < SEGMENT_JOBS; k++) begin
        j.setup_time      = pick_duration();
        j.processing_time = pick_duration();
        j.last_job        = (k == len - 1);
        send_job(j);
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] cfg_plan [12];
    cfg_plan = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd9, 5'd17, 5'd4, 5'd3, 5'd24, 5'd12, 5'd0};
    cfg_plan[11] = CFG_W'($urandom_range(0, 31));
    sb = new();
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    job_if.valid           = 1'b0;
    job_if.setup_time      = '0;
    job_if.processing_time = '0;
    job_if.last_job        = 1'b0;
    send_idle_pct          = 8;
    recv_stall_pct         = 54;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset count, extremes of both durations, then closing
    send_fields(0, 0, 0);
    send_fields(DUR_TOP, DUR_TOP, 0);
    send_fields(0, DUR_TOP, 0);
    send_fields(DUR_TOP, 0, 0);
    send_fields(3, 0, 0);
    send_fields(7, 3, 1);
    // zero machines behaves as one
    write_machines(5'd0);
    send_fields(5, 5, 0);
    send_fields(2, 9, 1);
    // equal free times: lowest index wins
    write_machines(5'd3);
    send_fields(0, 0, 0);
    send_fields(0, 0, 0);
    send_fields(0, 0, 0);
    send_fields(4, 4, 0);
    // count changes inside an open schedule
    write_machines(5'd16);
    send_fields(10, 10, 0);
    send_fields(1, 2, 0);
    write_machines(5'd1);
    send_fields(1, 1, 0);
    send_fields(1, 1, 1);
    // count above the machine total is clamped
    write_machines(5'd31);
    send_fields(0, 1, 0);
    send_fields(0, 1, 1);

    // Random schedules under three idling patterns
    for (int m = 0; m < 3; m++) begin
      case (m)
        0:       begin send_idle_pct = 8;  recv_stall_pct = 54; end
        1:       begin send_idle_pct = 54; recv_stall_pct = 8;  end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      for (int s = 0; s < 4; s++) run_segment(cfg_plan[m * 4 + s]);
    end

    // Long chain of maximum durations on one machine, then a fresh schedule
    write_machines(5'd1);
    send_fields(0, 0, 1);
    for (int unsigned k = 0; k < LONG_JOBS; k++) send_fields(DUR_TOP, DUR_TOP, 0);
    send_fields(DUR_TOP, DUR_TOP, 1);
    send_fields(0, 0, 0);
    send_fields(1, 1, 1);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("shared_server_makespan_eval_top_tb: clean");
    end else begin
      $display("shared_server_makespan_eval_top_tb: errors");
    end
    $finish;
  end

endmodule
